FILE: hdl/preemptive_priority_scheduler_macros.svh
// Assertion macros for the preemptive priority scheduler.
// Included by preemptive_priority_scheduler.sv; assumes signals named clock and reset.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Checked outside reset only
`define PPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define PPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by preemptive_priority_scheduler.sv.
`timescale 1ns / 1ps

package pps_pkg;

   localparam int TIME_W = 16;   // time, arrival, burst and remaining work
   localparam int PRIO_W = 8;
   localparam int ID_W   = 4;    // width of the process id ports
   localparam int CT_W   = 17;   // completion and turnaround
   localparam int SUM_W  = 32;   // running totals

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_ACCUM,
      ST_RESULT
   } state_type;

   // One process table entry as held in the memory
   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

FILE: hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler with its process table in a synchronous memory.
// Depends on pps_pkg and preemptive_priority_scheduler_macros.svh.
`timescale 1ns / 1ps

// A load (req_mode low) keeps busy low and writes the entry straight into the
// process table; it gives no result. A tick (req_mode high) raises busy after
// the transfer and holds it through the result: the table memory is read one
// entry per cycle to find the eligible process with the smallest priority value
// (lower id wins a tie), a drain state compares the last entry returned, an
// update state writes back its remaining work and forms the timing figures, an
// accumulate state updates the totals and clock, and a result state presents
// the result. The result is on the rsp_ ports, marked by rsp_strobe for exactly
// one cycle, and must be taken then: the receiver cannot hold it off. Every tick
// gives one result, idle ticks included. Per-entry valid bits stand in for the
// table's reset, so no clearing pass is needed after reset.
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [pps_pkg::ID_W-1:0]      req_process_id,
   input  logic [pps_pkg::TIME_W-1:0]    req_arrival_time,
   input  logic [pps_pkg::TIME_W-1:0]    req_burst_length,
   input  logic [pps_pkg::PRIO_W-1:0]    req_priority_req,
   // result channel
   output logic                          rsp_strobe,
   output logic                          rsp_ran_valid,
   output logic [pps_pkg::ID_W-1:0]      rsp_ran_id,
   output logic                          rsp_finished,
   output logic [pps_pkg::CT_W-1:0]      rsp_completion_time,
   output logic [pps_pkg::CT_W-1:0]      rsp_turnaround,
   output logic [pps_pkg::TIME_W-1:0]    rsp_waiting,
   output logic [pps_pkg::SUM_W-1:0]     rsp_total_waiting,
   output logic [pps_pkg::SUM_W-1:0]     rsp_total_turnaround
);

`include "preemptive_priority_scheduler_macros.svh"

   localparam int IDX_W  = $clog2(MAX_PROCS);
   localparam int WIDE_W = (IDX_W > pps_pkg::ID_W) ? IDX_W : pps_pkg::ID_W;
   localparam int TW     = pps_pkg::TIME_W;
   localparam int CW     = pps_pkg::CT_W;
   localparam int SW     = pps_pkg::SUM_W;
   localparam int SXW    = pps_pkg::SUM_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);
   localparam logic [TW-1:0]    TIME_MAX = '1;

   // control
   pps_pkg::state_type state_ff, state_in;
   logic               tick_accept, load_accept, load_ok;

   // process table
   pps_pkg::entry_type mem_ram [MAX_PROCS];
   logic               valid_ff [MAX_PROCS];
   logic               mem_we;
   logic [IDX_W-1:0]   wr_idx;
   pps_pkg::entry_type wr_data;
   logic [WIDE_W-1:0]  load_id_wide;
   logic [IDX_W-1:0]   load_idx;

   // scan
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_tag_ff;
   pps_pkg::entry_type rd_data_ff;
   logic               vbit_rd_ff;
   logic               rd_elig;

   // best candidate so far
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   best_id_ff, best_id_in;
   pps_pkg::entry_type best_ff, best_in;
   logic [WIDE_W-1:0]  best_id_wide;

   // timing figures
   logic [CW-1:0]      completion_calc, turn_calc, wait_diff;
   logic [TW-1:0]      wait_calc;
   logic               fin_calc;

   // result and running state
   logic               ran_valid_ff, ran_valid_in;
   logic [pps_pkg::ID_W-1:0] ran_id_ff, ran_id_in;
   logic               finished_ff, finished_in;
   logic [CW-1:0]      completion_ff, completion_in;
   logic [CW-1:0]      turnaround_ff, turnaround_in;
   logic [TW-1:0]      waiting_ff, waiting_in;
   logic [TW-1:0]      time_ff, time_in;
   logic [SW-1:0]      sum_wait_ff, sum_wait_in;
   logic [SW-1:0]      sum_turn_ff, sum_turn_in;
   logic [SXW-1:0]     wait_acc, turn_acc;

   // ---------------------------------------------------------------
   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (start && req_mode == pps_pkg::MODE_TICK) state_in = pps_pkg::ST_SCAN;
         end
         pps_pkg::ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) state_in = pps_pkg::ST_DRAIN;
         end
         pps_pkg::ST_DRAIN:  state_in = pps_pkg::ST_UPDATE;
         pps_pkg::ST_UPDATE: state_in = pps_pkg::ST_ACCUM;
         pps_pkg::ST_ACCUM:  state_in = pps_pkg::ST_RESULT;
         pps_pkg::ST_RESULT: state_in = pps_pkg::ST_IDLE;
         default:            state_in = pps_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // State-decoded outputs and table write port
   assign load_id_wide = WIDE_W'(req_process_id);
   assign load_idx     = load_id_wide[IDX_W-1:0];
   assign load_ok      = (32'(req_process_id) < 32'(MAX_PROCS));

   always_comb begin
      busy        = (state_ff != pps_pkg::ST_IDLE);
      rsp_strobe  = (state_ff == pps_pkg::ST_RESULT);
      tick_accept = start && !busy && (req_mode == pps_pkg::MODE_TICK);
      load_accept = start && !busy && (req_mode == pps_pkg::MODE_LOAD);
      rd_vld_in   = (state_ff == pps_pkg::ST_SCAN);
      mem_we      = 1'b0;
      wr_idx      = load_idx;
      wr_data.arrival   = req_arrival_time;
      wr_data.burst     = req_burst_length;
      wr_data.remaining = req_burst_length;
      wr_data.prio      = req_priority_req;
      if (load_accept && load_ok) begin
         mem_we = 1'b1;
      end else if (state_ff == pps_pkg::ST_UPDATE && found_ff) begin
         // write back one unit of work less
         mem_we            = 1'b1;
         wr_idx            = best_id_ff;
         wr_data           = best_ff;
         wr_data.remaining = best_ff.remaining - TW'(1);
      end
   end

   // ---------------------------------------------------------------
   // Process table memory, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem_ram[scan_idx_ff];
   end

   // Entry valid bits stand for the cleared table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCS; i++) valid_ff[i] <= 1'b0;
         vbit_rd_ff <= 1'b0;
      end else begin
         if (load_accept && load_ok) valid_ff[load_idx] <= 1'b1;
         vbit_rd_ff <= valid_ff[scan_idx_ff];
      end
   end

   // ---------------------------------------------------------------
   // Scan: compare each returned entry against the best so far
   assign rd_elig = vbit_rd_ff && (rd_data_ff.remaining != '0)
                    && (rd_data_ff.arrival <= time_ff);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (tick_accept) scan_idx_in = '0;
      else if (state_ff == pps_pkg::ST_SCAN) scan_idx_in = scan_idx_ff + IDX_W'(1);

      found_in   = found_ff;
      best_id_in = best_id_ff;
      best_in    = best_ff;
      if (tick_accept) begin
         found_in = 1'b0;
      end else if (rd_vld_ff && rd_elig && (!found_ff || rd_data_ff.prio < best_ff.prio)) begin
         // strict compare in ascending id order keeps the lower id on a tie
         found_in   = 1'b1;
         best_id_in = rd_tag_ff;
         best_in    = rd_data_ff;
      end
   end

   // ---------------------------------------------------------------
   // Timing figures of the chosen process
   assign best_id_wide    = WIDE_W'(best_id_ff);
   assign completion_calc = {1'b0, time_ff} + CW'(1);
   assign turn_calc       = completion_calc - {1'b0, best_ff.arrival};
   assign wait_diff       = turn_calc - {1'b0, best_ff.burst};
   assign wait_calc       = (turn_calc > {1'b0, best_ff.burst}) ? wait_diff[TW-1:0] : '0;
   assign fin_calc        = found_ff && (best_ff.remaining == TW'(1));

   // saturating totals
   assign wait_acc = {1'b0, sum_wait_ff} + SXW'(waiting_ff);
   assign turn_acc = {1'b0, sum_turn_ff} + SXW'(turnaround_ff);

   always_comb begin
      ran_valid_in  = ran_valid_ff;
      ran_id_in     = ran_id_ff;
      finished_in   = finished_ff;
      completion_in = completion_ff;
      turnaround_in = turnaround_ff;
      waiting_in    = waiting_ff;
      time_in       = time_ff;
      sum_wait_in   = sum_wait_ff;
      sum_turn_in   = sum_turn_ff;
      if (state_ff == pps_pkg::ST_UPDATE) begin
         ran_valid_in  = found_ff;
         ran_id_in     = found_ff ? best_id_wide[pps_pkg::ID_W-1:0] : '0;
         finished_in   = fin_calc;
         completion_in = fin_calc ? completion_calc : '0;
         turnaround_in = fin_calc ? turn_calc : '0;
         waiting_in    = fin_calc ? wait_calc : '0;
      end
      if (state_ff == pps_pkg::ST_ACCUM) begin
         if (finished_ff) begin
            sum_wait_in = wait_acc[SW] ? '1 : wait_acc[SW-1:0];
            sum_turn_in = turn_acc[SW] ? '1 : turn_acc[SW-1:0];
         end
         if (time_ff != TIME_MAX) time_in = time_ff + TW'(1);
      end
   end

   // ---------------------------------------------------------------
   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pps_pkg::ST_IDLE;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         ran_valid_ff <= 1'b0;
         finished_ff  <= 1'b0;
         time_ff      <= '0;
         sum_wait_ff  <= '0;
         sum_turn_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         ran_valid_ff <= ran_valid_in;
         finished_ff  <= finished_in;
         time_ff      <= time_in;
         sum_wait_ff  <= sum_wait_in;
         sum_turn_ff  <= sum_turn_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_tag_ff     <= scan_idx_ff;
      best_id_ff    <= best_id_in;
      best_ff       <= best_in;
      ran_id_ff     <= ran_id_in;
      completion_ff <= completion_in;
      turnaround_ff <= turnaround_in;
      waiting_ff    <= waiting_in;
   end

   // result ports
   assign rsp_ran_valid        = ran_valid_ff;
   assign rsp_ran_id           = ran_id_ff;
   assign rsp_finished         = finished_ff;
   assign rsp_completion_time  = completion_ff;
   assign rsp_turnaround       = turnaround_ff;
   assign rsp_waiting          = waiting_ff;
   assign rsp_total_waiting    = sum_wait_ff;
   assign rsp_total_turnaround = sum_turn_ff;

   // ---------------------------------------------------------------
   // Assertions
   `PPS_ASSERT_ALWAYS(a_strobe_busy, rsp_strobe |-> busy, "result strobe while idle")
   `PPS_ASSERT(a_single_result, rsp_strobe |=> !rsp_strobe, "tick gave more than one result")
   `PPS_ASSERT(a_finish_ran,
               rsp_strobe && rsp_finished |-> rsp_ran_valid,
               "finish without a run")
   `PPS_ASSERT(a_wait_le_turn,
               rsp_strobe && rsp_finished |-> CW'(rsp_waiting) <= rsp_turnaround,
               "waiting exceeds turnaround")
   `PPS_ASSERT(a_no_write_in_scan,
               (state_ff == pps_pkg::ST_SCAN || state_ff == pps_pkg::ST_DRAIN) |-> !mem_we,
               "table written during scan")

endmodule

FILE: bench/preemptive_priority_scheduler_tb.sv
// Self-checking bench for the preemptive priority scheduler: loads and ticks are driven
// from a queue, and tick reports are checked against a behavioural model of the table.
// Depends on pps_pkg and on the preemptive_priority_scheduler RTL.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;
   import pps_pkg::*;

   localparam int NUM_SLOTS = 16;
   localparam int FIFO_DEPTH = 32;

   // One command as queued for the driver; gap is the idle cycles before it
   typedef struct packed {
      logic              mode;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      logic [7:0]        gap;
   } sched_cmd_type;

   // What one tick reports
   typedef struct packed {
      logic              ran_valid;
      logic [ID_W-1:0]   ran_id;
      logic              finished;
      logic [CT_W-1:0]   completion;
      logic [CT_W-1:0]   turnaround;
      logic [TIME_W-1:0] waiting;
      logic [SUM_W-1:0]  total_waiting;
      logic [SUM_W-1:0]  total_turnaround;
   } tick_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              start            = 1'b0;
   logic              req_mode         = MODE_LOAD;
   logic [ID_W-1:0]   req_process_id   = '0;
   logic [TIME_W-1:0] req_arrival_time = '0;
   logic [TIME_W-1:0] req_burst_length = '0;
   logic [PRIO_W-1:0] req_priority_req = '0;

   logic              busy;
   logic              rsp_strobe;
   logic              rsp_ran_valid;
   logic [ID_W-1:0]   rsp_ran_id;
   logic              rsp_finished;
   logic [CT_W-1:0]   rsp_completion_time;
   logic [CT_W-1:0]   rsp_turnaround;
   logic [TIME_W-1:0] rsp_waiting;
   logic [SUM_W-1:0]  rsp_total_waiting;
   logic [SUM_W-1:0]  rsp_total_turnaround;

   // Process table model and scheduler clock
   logic [TIME_W-1:0] slot_arrival [NUM_SLOTS];
   logic [TIME_W-1:0] slot_burst   [NUM_SLOTS];
   logic [TIME_W-1:0] slot_left    [NUM_SLOTS] = '{default: '0};
   logic [PRIO_W-1:0] slot_prio    [NUM_SLOTS];
   logic [TIME_W-1:0] now_tick   = '0;
   logic [SUM_W-1:0]  model_wait = '0;
   logic [SUM_W-1:0]  model_turn = '0;

   sched_cmd_type   cmd_fifo [$];
   tick_report_type report_q [$];
   sched_cmd_type   next_cmd;
   sched_cmd_type   seen_cmd;
   tick_report_type exp_rpt;
   tick_report_type new_rpt;

   logic start_taken = 1'b0;
   int   idle_count  = 0;
   logic no_idle     = 1'b0;
   int   gen_time    = 0;

   int n_loads_queued  = 0;
   int n_ticks_queued  = 0;
   int n_accepted      = 0;
   int reports_checked = 0;
   int completions     = 0;
   int mismatches      = 0;

   preemptive_priority_scheduler #(
      .MAX_PROCS(NUM_SLOTS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_process_id      (req_process_id),
      .req_arrival_time    (req_arrival_time),
      .req_burst_length    (req_burst_length),
      .req_priority_req    (req_priority_req),
      .rsp_strobe          (rsp_strobe),
      .rsp_ran_valid       (rsp_ran_valid),
      .rsp_ran_id          (rsp_ran_id),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_total_waiting   (rsp_total_waiting),
      .rsp_total_turnaround(rsp_total_turnaround)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [SUM_W-1:0] sat_add32(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   // Applies one command to the table model; returns 1 with the report for a tick
   function automatic logic schedule_step(input sched_cmd_type cmd,
                                          output tick_report_type rpt);
      logic            found;
      logic [ID_W-1:0] pick;
      logic [CT_W-1:0] done_at;
      logic [CT_W-1:0] turn;
      rpt = '0;
      if (cmd.mode == MODE_LOAD) begin
         slot_arrival[cmd.id] = cmd.arrival;
         slot_burst[cmd.id]   = cmd.burst;
         slot_left[cmd.id]    = cmd.burst;
         slot_prio[cmd.id]    = cmd.prio;
         return 1'b0;
      end
      // smallest priority value among arrived live entries, lower id on a tie
      found = 1'b0;
      pick  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_left[i] != '0 && slot_arrival[i] <= now_tick &&
             (!found || slot_prio[i] < slot_prio[pick])) begin
            found = 1'b1;
            pick  = ID_W'(i);
         end
      end
      if (found) begin
         rpt.ran_valid   = 1'b1;
         rpt.ran_id      = pick;
         slot_left[pick] = slot_left[pick] - 1'b1;
         if (slot_left[pick] == '0) begin
            done_at        = {1'b0, now_tick} + 1'b1;
            turn           = done_at - {1'b0, slot_arrival[pick]};
            rpt.finished   = 1'b1;
            rpt.completion = done_at;
            rpt.turnaround = turn;
            // waiting clamps at zero once the clock has stuck
            rpt.waiting    = (turn > {1'b0, slot_burst[pick]}) ?
                             TIME_W'(turn - {1'b0, slot_burst[pick]}) : '0;
            model_wait = sat_add32(model_wait, SUM_W'(rpt.waiting));
            model_turn = sat_add32(model_turn, SUM_W'(turn));
         end
      end
      if (now_tick != '1)
         now_tick = now_tick + 1'b1;
      rpt.total_waiting    = model_wait;
      rpt.total_turnaround = model_turn;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [SUM_W-1:0] want,
                                       input logic [SUM_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH report %0d, %s: expected %0d, got %0d",
                     reports_checked, name, want, got);
      end
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic logic [7:0] pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 8'd0;
      if (r < 90)
         return 8'($urandom_range(1, 3));
      return 8'($urandom_range(4, 60));
   endfunction

   task automatic queue_command(input logic mode, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] arrival,
                                input logic [TIME_W-1:0] burst,
                                input logic [PRIO_W-1:0] prio, input logic [7:0] gap);
      sched_cmd_type cmd;
      while (cmd_fifo.size() >= FIFO_DEPTH)
         @(negedge clock);
      cmd.mode    = mode;
      cmd.id      = id;
      cmd.arrival = arrival;
      cmd.burst   = burst;
      cmd.prio    = prio;
      cmd.gap     = gap;
      cmd_fifo = {cmd_fifo, cmd};
      if (mode == MODE_TICK) begin
         n_ticks_queued++;
         if (gen_time < 65535)
            gen_time++;
      end else begin
         n_loads_queued++;
      end
   endtask

   // Load fields carry junk on a tick; the block must ignore them
   task automatic queue_tick(input logic [7:0] gap);
      queue_command(MODE_TICK, ID_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
                    PRIO_W'($urandom), gap);
   endtask

   task automatic queue_random_item();
      int                r;
      int                a;
      logic [TIME_W-1:0] arr;
      logic [TIME_W-1:0] len;
      logic [PRIO_W-1:0] pr;
      if ($urandom_range(0, 99) >= 40) begin
         queue_tick(pick_gap());
         return;
      end
      // arrival mostly near the current tick, some late, some anywhere
      r = $urandom_range(0, 9);
      if (r == 0) begin
         arr = '0;
      end else if (r <= 2) begin
         a = gen_time - int'($urandom_range(0, 20));
         arr = (a < 0) ? '0 : TIME_W'(a);
      end else if (r == 3) begin
         arr = TIME_W'($urandom);
      end else begin
         a = gen_time + int'($urandom_range(0, 6));
         arr = (a > 65535) ? '1 : TIME_W'(a);
      end
      r = $urandom_range(0, 99);
      if (r < 2)
         len = '0;
      else if (r < 70)
         len = TIME_W'($urandom_range(1, 6));
      else if (r < 90)
         len = TIME_W'($urandom_range(7, 40));
      else
         len = TIME_W'($urandom_range(1, 65535));
      // narrow priority range most of the time so ties are common
      pr = ($urandom_range(0, 99) < 60) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
      queue_command(MODE_LOAD, ID_W'($urandom_range(0, NUM_SLOTS - 1)), arr, len, pr,
                    pick_gap());
   endtask

   // Driver: present the next command once the previous transfer has happened
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || start_taken) begin
         if (cmd_fifo.size() != 0 && idle_count >= cmd_fifo[0].gap) begin
            next_cmd = cmd_fifo.pop_front();
            start            <= 1'b1;
            req_mode         <= next_cmd.mode;
            req_process_id   <= next_cmd.id;
            req_arrival_time <= next_cmd.arrival;
            req_burst_length <= next_cmd.burst;
            req_priority_req <= next_cmd.prio;
            idle_count       <= 0;
         end else begin
            start      <= 1'b0;
            idle_count <= idle_count + 1;
         end
      end
   end

   // Monitor: check reports, then log accepted commands into the model
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (report_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("MISMATCH: tick report with nothing outstanding (ran_id %0d)",
                        rsp_ran_id);
         end else begin
            exp_rpt = report_q.pop_front();
            check_field("ran_valid", exp_rpt.ran_valid, rsp_ran_valid);
            check_field("ran_id", exp_rpt.ran_id, rsp_ran_id);
            check_field("finished", exp_rpt.finished, rsp_finished);
            check_field("completion_time", exp_rpt.completion, rsp_completion_time);
            check_field("turnaround", exp_rpt.turnaround, rsp_turnaround);
            check_field("waiting", exp_rpt.waiting, rsp_waiting);
            check_field("total_waiting", exp_rpt.total_waiting, rsp_total_waiting);
            check_field("total_turnaround", exp_rpt.total_turnaround,
                        rsp_total_turnaround);
            reports_checked++;
            if (exp_rpt.finished)
               completions++;
         end
      end
      start_taken <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         n_accepted++;
         seen_cmd.mode    = req_mode;
         seen_cmd.id      = req_process_id;
         seen_cmd.arrival = req_arrival_time;
         seen_cmd.burst   = req_burst_length;
         seen_cmd.prio    = req_priority_req;
         seen_cmd.gap     = '0;
         if (schedule_step(seen_cmd, new_rpt))
            report_q = {report_q, new_rpt};
      end
   end

   // Stimulus and end of run
   initial begin
      int leftover;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle tick, zero burst, ties, preemption, reload, late arrival, maxima
      queue_tick(pick_gap());
      queue_command(MODE_LOAD, 4'd0, 16'd0, 16'd1, 8'd255, pick_gap());
      queue_tick(pick_gap());
      queue_command(MODE_LOAD, 4'd5, 16'd0, 16'd0, 8'd0, pick_gap());
      queue_tick(pick_gap());
      queue_command(MODE_LOAD, 4'd3, 16'd0, 16'd3, 8'd7, pick_gap());
      queue_command(MODE_LOAD, 4'd9, 16'd0, 16'd1, 8'd7, pick_gap());
      queue_command(MODE_LOAD, 4'd12, 16'(gen_time + 2), 16'd1, 8'd0, pick_gap());
      queue_tick(pick_gap());
      queue_tick(pick_gap());
      queue_command(MODE_LOAD, 4'd3, 16'd1, 16'd2, 8'd7, pick_gap());
      queue_tick(pick_gap());
      queue_command(MODE_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'd255, pick_gap());
      queue_command(MODE_LOAD, 4'd6, 16'(gen_time - 3), 16'd2, 8'd1, pick_gap());
      queue_command(MODE_LOAD, 4'd10, 16'(gen_time), 16'd1, 8'd1, pick_gap());
      repeat (5) queue_tick(pick_gap());

      // random traffic, with stretches of no idling now and then
      for (int n = 0; n < 350; n++) begin
         if (n % 25 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         queue_random_item();
      end

      // a job arriving at the last tick value stays parked while others run
      no_idle = 1'b0;
      queue_command(MODE_LOAD, 4'd2, 16'hFFFF, 16'd4, 8'd0, pick_gap());
      repeat (4) queue_tick(pick_gap());
      for (int n = 0; n < 30; n++)
         queue_random_item();
      queue_tick(pick_gap());

      // wait for every transfer, then for the outstanding reports
      while (n_accepted != n_loads_queued + n_ticks_queued)
         @(posedge clock);
      for (int n = 0; n < 300 && report_q.size() != 0; n++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      leftover = report_q.size();
      if (leftover != 0)
         $display("MISSING: %0d tick reports never arrived", leftover);

      $display("Covered %0d loads and %0d ticks; %0d reports checked, %0d completions.",
               n_loads_queued, n_ticks_queued, reports_checked, completions);
      $display("Scheduler clock ended at %0d, field mismatches: %0d.",
               now_tick, mismatches);
      if (mismatches == 0 && leftover == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #100_000_000;
      $display("Timed out: %0d of %0d commands transferred, %0d reports outstanding",
               n_accepted, n_loads_queued + n_ticks_queued, report_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/pps_pkg.sv
hdl/preemptive_priority_scheduler.sv
bench/preemptive_priority_scheduler_tb.sv
